// ===== rtl/core/qst_pkg.sv =====
// shared types, constants and lookup functions for the smallest-three quaternion packer
// no dependencies
`timescale 1ns / 1ps

package qst_pkg;

   // drop codes as they appear in bits 31:30 of the packed word
   localparam logic [1:0] DROP_X = 2'd0;
   localparam logic [1:0] DROP_Y = 2'd1;
   localparam logic [1:0] DROP_Z = 2'd2;
   localparam logic [1:0] DROP_W = 2'd3;

   // component index in w,x,y,z order
   localparam logic [1:0] COMP_W = 2'd0;
   localparam logic [1:0] COMP_X = 2'd1;
   localparam logic [1:0] COMP_Y = 2'd2;
   localparam logic [1:0] COMP_Z = 2'd3;

   localparam int SEARCH_BITS = 9;
   localparam int CODE_BITS   = 10;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = 2;

   localparam logic [CODE_BITS-1:0] CODE_MID = 10'd512;
   localparam logic [CODE_BITS-1:0] CODE_NEG_BASE = 10'd511;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   function automatic logic [1:0] drop_code(input logic [1:0] comp);
      logic [1:0] code;
      case (comp)
         COMP_W: code = DROP_W;
         COMP_X: code = DROP_X;
         COMP_Y: code = DROP_Y;
         COMP_Z: code = DROP_Z;
         default: code = DROP_W;
      endcase
      return code;
   endfunction

   // source component of each kept field, field 0 in the low bits
   function automatic logic [1:0] kept_src(input logic [1:0] code, input logic [1:0] lane);
      logic [5:0] row;
      case (code)
         DROP_X: row = {COMP_W, COMP_Z, COMP_Y};
         DROP_Y: row = {COMP_W, COMP_Z, COMP_X};
         DROP_Z: row = {COMP_W, COMP_Y, COMP_X};
         DROP_W: row = {COMP_Z, COMP_Y, COMP_X};
         default: row = {COMP_Z, COMP_Y, COMP_X};
      endcase
      case (lane)
         2'd0: return row[1:0];
         2'd1: return row[3:2];
         2'd2: return row[5:4];
         default: return row[1:0];
      endcase
   endfunction

endpackage

// ===== rtl/core/quaternion_smallest_three_pack.sv =====
// Smallest-three quaternion packer, 10-10-10-2 format.
// Request channel (req_valid/req_ready): one quaternion w,x,y,z, each a signed
// COMPONENT_BITS value with 14 fraction bits.
// Response channel (rsp_valid/rsp_ready): one 32-bit word per quaternion, bits
// 31:30 the drop code (w=3, x=0, y=1, z=2), bits 29:0 three 10-bit codes.
// Throughput: one quaternion per cycle, sustained, with no bubbles, while the receiver keeps rsp_ready high.
// Fourteen registers in line from request to response, the first loaded at the
// request transfer: three front stages (magnitude, square, sum), one queue slot,
// nine search stages (one code bit each, all three kept codes in parallel) and
// the output register. The nine-bit search sets the depth of the back end.
// A four-entry queue parts the front end from the back end; a stalled receiver
// freezes the back end, the queue fills, and only then req_ready drops.
// Reset (synchronous) empties the pipelines and the queue; no clearing pass.
// depends on qst_pkg, qst_front, qst_queue, qst_back
`timescale 1ns / 1ps

module quaternion_smallest_three_pack #(
   parameter int COMPONENT_BITS = 18
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [COMPONENT_BITS-1:0] req_quat_w,
   input  logic signed [COMPONENT_BITS-1:0] req_quat_x,
   input  logic signed [COMPONENT_BITS-1:0] req_quat_y,
   input  logic signed [COMPONENT_BITS-1:0] req_quat_z,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [31:0]                      rsp_packed_rotation
);

   localparam int IW = 2*COMPONENT_BITS+2+3*(2*COMPONENT_BITS+20)+6;

   logic          f_valid;
   logic [IW-1:0] f_item;
   logic          q_push;
   logic          q_pop;
   logic [IW-1:0] q_data;
   qst_pkg::fifo_status_type q_status;

   qst_front #(.COMPONENT_BITS(COMPONENT_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_quat_w (req_quat_w),
      .req_quat_x (req_quat_x),
      .req_quat_y (req_quat_y),
      .req_quat_z (req_quat_z),
      .out_valid  (f_valid),
      .out_ready  (!q_status.full),
      .out_item   (f_item)
   );

   assign q_push = f_valid && !q_status.full;

   qst_queue #(.WIDTH(IW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (f_item),
      .pop       (q_pop),
      .pop_data  (q_data),
      .status    (q_status)
   );

   logic b_ready;

   assign q_pop = b_ready && !q_status.empty;

   qst_back #(.COMPONENT_BITS(COMPONENT_BITS)) u_back (
      .clock               (clock),
      .reset               (reset),
      .in_valid            (!q_status.empty),
      .in_ready            (b_ready),
      .in_item             (q_data),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_packed_rotation (rsp_packed_rotation)
   );

   // nothing comes out in the cycle after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_queue_flags: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue full and empty at once");

   // the front end only holds off requests while it has an item waiting
   a_front_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (f_valid && q_status.full))
      else $error("request stalled without a waiting item");

endmodule

// ===== rtl/core/qst_front.sv =====
// front end: takes quaternions, forms magnitudes, squares, sum of squares, drop choice and scaled kept squares
// depends on qst_pkg
`timescale 1ns / 1ps

module qst_front #(
   parameter int COMPONENT_BITS = 18
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [COMPONENT_BITS-1:0]    req_quat_w,
   input  logic signed [COMPONENT_BITS-1:0]    req_quat_x,
   input  logic signed [COMPONENT_BITS-1:0]    req_quat_y,
   input  logic signed [COMPONENT_BITS-1:0]    req_quat_z,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic [2*COMPONENT_BITS+2+3*(2*COMPONENT_BITS+20)+5:0] out_item
);

   localparam int C  = COMPONENT_BITS;
   localparam int QW = 2 * C;
   localparam int SW = 2 * C + 2;
   localparam int RW = 2 * C + 20;

   logic adv;

   // stage a: sign and magnitude
   logic         a_vld_ff;
   logic [C-1:0] a_mag_ff [4];
   logic [C-1:0] a_mag_in [4];
   logic [3:0]   a_neg_ff;
   logic [3:0]   a_neg_in;
   logic [C-1:0] raw [4];

   // stage b: squares and largest component
   logic          b_vld_ff;
   logic [QW-1:0] b_sq_ff [4];
   logic [QW-1:0] b_sq_in [4];
   logic [3:0]    b_neg_ff;
   logic [3:0]    b_neg_in;
   logic [1:0]    b_best_ff;
   logic [1:0]    b_best_in;

   // stage c: sum, scaled kept squares
   logic          c_vld_ff;
   logic [SW-1:0] c_s_ff;
   logic [SW-1:0] c_s_in;
   logic [RW-1:0] c_r_ff [3];
   logic [RW-1:0] c_r_in [3];
   logic [2:0]    c_neg_ff;
   logic [2:0]    c_neg_in;
   logic          c_zero_ff;
   logic [1:0]    c_code_ff;
   logic [1:0]    c_code_in;

   assign adv       = !c_vld_ff || out_ready;
   assign req_ready = adv;
   assign out_valid = c_vld_ff;

   assign raw[0] = req_quat_w;
   assign raw[1] = req_quat_x;
   assign raw[2] = req_quat_y;
   assign raw[3] = req_quat_z;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         a_neg_in[i] = raw[i][C-1];
         // most negative value wraps to 2^(C-1), which is right as unsigned
         a_mag_in[i] = a_neg_in[i] ? (~raw[i] + C'(1)) : raw[i];
      end
   end

   always_comb begin
      logic [1:0] best;
      best = qst_pkg::COMP_W;
      if (a_mag_ff[1] > a_mag_ff[best]) best = qst_pkg::COMP_X;
      if (a_mag_ff[2] > a_mag_ff[best]) best = qst_pkg::COMP_Y;
      if (a_mag_ff[3] > a_mag_ff[best]) best = qst_pkg::COMP_Z;
      b_best_in = best;
      for (int i = 0; i < 4; i++) begin
         b_sq_in[i]  = QW'(a_mag_ff[i]) * QW'(a_mag_ff[i]);
         b_neg_in[i] = a_neg_ff[i] ^ a_neg_ff[best];
      end
   end

   always_comb begin
      logic [1:0]    src;
      logic [RW-1:0] sq;
      c_s_in = SW'(b_sq_ff[0]) + SW'(b_sq_ff[1]) + SW'(b_sq_ff[2]) + SW'(b_sq_ff[3]);
      c_code_in = qst_pkg::drop_code(b_best_ff);
      for (int l = 0; l < 3; l++) begin
         src = qst_pkg::kept_src(c_code_in, 2'(l));
         sq  = RW'(b_sq_ff[src]);
         // times 1023^2 = 2^20 - 2^11 + 1
         c_r_in[l]   = (sq << 20) - (sq << 11) + sq;
         c_neg_in[l] = b_neg_ff[src] && (b_sq_ff[src] != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= req_valid;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_mag_ff  <= a_mag_in;
         a_neg_ff  <= a_neg_in;
         b_sq_ff   <= b_sq_in;
         b_neg_ff  <= b_neg_in;
         b_best_ff <= b_best_in;
         c_s_ff    <= c_s_in;
         c_r_ff    <= c_r_in;
         c_neg_ff  <= c_neg_in;
         c_zero_ff <= (c_s_in == '0);
         c_code_ff <= c_code_in;
      end
   end

   assign out_item = {c_code_ff, c_zero_ff, c_neg_ff, c_r_ff[2], c_r_ff[1], c_r_ff[0], c_s_ff};

endmodule

// ===== rtl/core/qst_queue.sv =====
// short queue between front and back end
// depends on qst_pkg
`timescale 1ns / 1ps

module qst_queue #(
   parameter int WIDTH = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  logic [WIDTH-1:0]        push_data,
   input  logic                    pop,
   output logic [WIDTH-1:0]        pop_data,
   output qst_pkg::fifo_status_type status
);

   logic [WIDTH-1:0] mem_ff [qst_pkg::QUEUE_DEPTH];
   logic [qst_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [qst_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [qst_pkg::QUEUE_PTR_BITS:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + (push ? 1'b1 : 1'b0);
      rd_ptr_in = rd_ptr_ff + (pop ? 1'b1 : 1'b0);
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

   assign pop_data     = mem_ff[rd_ptr_ff];
   assign status.full  = (count_ff == (qst_pkg::QUEUE_PTR_BITS+1)'(qst_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

// ===== rtl/core/qst_back.sv =====
// back end: bit-serial pipelined search of each kept code, then packing
// depends on qst_pkg
`timescale 1ns / 1ps

module qst_back #(
   parameter int COMPONENT_BITS = 18
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [2*COMPONENT_BITS+2+3*(2*COMPONENT_BITS+20)+5:0] in_item,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [31:0]          rsp_packed_rotation
);

   localparam int C  = COMPONENT_BITS;
   localparam int SW = 2 * C + 2;
   localparam int RW = 2 * C + 20;
   localparam int W  = 2 * C + 22;
   localparam int NB = qst_pkg::SEARCH_BITS;
   localparam int CB = qst_pkg::CODE_BITS;

   logic adv;

   // unpack the queue head
   logic [SW-1:0] h_s;
   logic [RW-1:0] h_r [3];
   logic [2:0]    h_neg;
   logic          h_zero;
   logic [1:0]    h_code;

   assign {h_code, h_zero, h_neg, h_r[2], h_r[1], h_r[0], h_s} = in_item;

   // stage j holds the remainder after deciding search bit NB-1-j
   logic          vld_ff  [NB];
   logic [W-1:0]  d_ff    [NB][3];
   logic [W-1:0]  p_ff    [NB][3];
   logic [NB-1:0] n_ff    [NB][3];
   logic [SW-1:0] s_ff    [NB];
   logic [2:0]    neg_ff  [NB];
   logic          zero_ff [NB];
   logic [1:0]    code_ff [NB];

   logic          rsp_valid_ff;
   logic [31:0]   rsp_word_ff, rsp_word_in;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign in_ready  = adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_packed_rotation = rsp_word_ff;

   for (genvar j = 0; j < NB; j++) begin : g_stage
      localparam int K = NB - 1 - j;
      logic          v_src;
      logic [W-1:0]  d_src [3];
      logic [W-1:0]  p_src [3];
      logic [NB-1:0] n_src [3];
      logic [SW-1:0] s_src;
      logic [2:0]    neg_src;
      logic          zero_src;
      logic [1:0]    code_src;
      logic [W-1:0]  d_in [3];
      logic [W-1:0]  p_in [3];
      logic [NB-1:0] n_in [3];

      if (j == 0) begin : g_head
         always_comb begin
            v_src    = in_valid;
            s_src    = h_s;
            neg_src  = h_neg;
            zero_src = h_zero;
            code_src = h_code;
            for (int l = 0; l < 3; l++) begin
               d_src[l] = W'(h_r[l]);
               p_src[l] = '0;
               n_src[l] = '0;
            end
         end
      end else begin : g_chain
         always_comb begin
            v_src    = vld_ff[j-1];
            s_src    = s_ff[j-1];
            neg_src  = neg_ff[j-1];
            zero_src = zero_ff[j-1];
            code_src = code_ff[j-1];
            d_src    = d_ff[j-1];
            p_src    = p_ff[j-1];
            n_src    = n_ff[j-1];
         end
      end

      // 2(n+2^K)^2 S - 2n^2 S = (2nS << (K+1)) + (S << (2K+1))
      always_comb begin
         logic [W-1:0] t;
         logic         take;
         for (int l = 0; l < 3; l++) begin
            t    = (p_src[l] << (K + 1)) + (W'(s_src) << (2 * K + 1));
            take = neg_src[l] ? (t < d_src[l]) : (t <= d_src[l]);
            d_in[l] = take ? (d_src[l] - t) : d_src[l];
            p_in[l] = take ? (p_src[l] + (W'(s_src) << (K + 1))) : p_src[l];
            n_in[l] = take ? (n_src[l] | (NB'(1) << K)) : n_src[l];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (adv) begin
            vld_ff[j] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            d_ff[j]    <= d_in;
            p_ff[j]    <= p_in;
            n_ff[j]    <= n_in;
            s_ff[j]    <= s_src;
            neg_ff[j]  <= neg_src;
            zero_ff[j] <= zero_src;
            code_ff[j] <= code_src;
         end
      end
   end

   always_comb begin
      logic [CB-1:0] q [3];
      for (int l = 0; l < 3; l++) begin
         if (zero_ff[NB-1]) begin
            q[l] = qst_pkg::CODE_MID;
         end else if (neg_ff[NB-1][l]) begin
            q[l] = qst_pkg::CODE_NEG_BASE - CB'(n_ff[NB-1][l]);
         end else begin
            q[l] = qst_pkg::CODE_MID + CB'(n_ff[NB-1][l]);
         end
      end
      rsp_word_in = {code_ff[NB-1], q[2], q[1], q[0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= vld_ff[NB-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) rsp_word_ff <= rsp_word_in;
   end

endmodule

// ===== tb/sv/qst_checker.sv =====
// checker for the smallest-three quaternion packer: watches both channels,
// predicts each packed word in exact integer arithmetic and compares
// depends on qst_pkg
`timescale 1ns / 1ps

module qst_checker #(
   parameter int COMPONENT_BITS = 18
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic signed [COMPONENT_BITS-1:0] req_quat_w,
   input  logic signed [COMPONENT_BITS-1:0] req_quat_x,
   input  logic signed [COMPONENT_BITS-1:0] req_quat_y,
   input  logic signed [COMPONENT_BITS-1:0] req_quat_z,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic [31:0]                      rsp_packed_rotation,
   output int                               error_count,
   output int                               pending_words
);

   logic [31:0] expected_words[$];

   // code for one kept component given its magnitude, sign and the squared length
   function automatic logic [9:0] quantize_lane(input logic [63:0] mag, input logic flip,
                                                input logic [127:0] sumsq);
      logic [127:0] rhs;
      logic [127:0] lhs;
      int           n;
      rhs = 128'(1023 * 1023) * 128'(mag) * 128'(mag);
      n = 0;
      if (!flip) begin
         while (n < 511) begin
            lhs = 128'(2 * (n + 1) * (n + 1)) * sumsq;
            if (lhs > rhs) break;
            n++;
         end
         return 10'(512 + n);
      end
      while (n < 512) begin
         lhs = 128'(2 * n * n) * sumsq;
         if (lhs >= rhs) break;
         n++;
      end
      return 10'(512 - n);
   endfunction

   function automatic logic [31:0] pack_rotation(input logic signed [COMPONENT_BITS-1:0] w,
                                                 input logic signed [COMPONENT_BITS-1:0] x,
                                                 input logic signed [COMPONENT_BITS-1:0] y,
                                                 input logic signed [COMPONENT_BITS-1:0] z);
      logic signed [COMPONENT_BITS-1:0] comp[4];
      logic [63:0]  mag[4];
      logic         neg[4];
      logic [127:0] sumsq;
      logic [1:0]   largest;
      logic [1:0]   code;
      logic [1:0]   src;
      logic [31:0]  word;
      logic [9:0]   q;
      comp[0] = w; comp[1] = x; comp[2] = y; comp[3] = z;
      sumsq = '0;
      for (int i = 0; i < 4; i++) begin
         neg[i] = comp[i] < 0;
         mag[i] = neg[i] ? 64'(-64'(comp[i])) : 64'(comp[i]);
         sumsq += 128'(mag[i]) * 128'(mag[i]);
      end
      largest = qst_pkg::COMP_W;
      for (int i = 1; i < 4; i++)
         if (mag[i] > mag[largest]) largest = 2'(i);
      if (neg[largest])
         for (int i = 0; i < 4; i++) neg[i] = !neg[i];
      case (largest)
         qst_pkg::COMP_W: code = qst_pkg::DROP_W;
         qst_pkg::COMP_X: code = qst_pkg::DROP_X;
         qst_pkg::COMP_Y: code = qst_pkg::DROP_Y;
         default: code = qst_pkg::DROP_Z;
      endcase
      word = {code, 30'd0};
      for (int lane = 0; lane < 3; lane++) begin
         // kept components in x,y,z,w order with the dropped one skipped, so w is last
         case (code)
            qst_pkg::DROP_X: src = (lane == 0) ? qst_pkg::COMP_Y :
                                   (lane == 1) ? qst_pkg::COMP_Z : qst_pkg::COMP_W;
            qst_pkg::DROP_Y: src = (lane == 0) ? qst_pkg::COMP_X :
                                   (lane == 1) ? qst_pkg::COMP_Z : qst_pkg::COMP_W;
            qst_pkg::DROP_Z: src = (lane == 0) ? qst_pkg::COMP_X :
                                   (lane == 1) ? qst_pkg::COMP_Y : qst_pkg::COMP_W;
            default: src = (lane == 0) ? qst_pkg::COMP_X :
                           (lane == 1) ? qst_pkg::COMP_Y : qst_pkg::COMP_Z;
         endcase
         if (sumsq == 0) q = qst_pkg::CODE_MID;
         else q = quantize_lane(mag[src], neg[src] && mag[src] != 0, sumsq);
         word[10*lane +: 10] = q;
      end
      return word;
   endfunction

   assign pending_words = expected_words.size();

   always @(posedge clock) begin
      logic [31:0] want;
      if (reset) begin
         expected_words.delete();
         error_count <= 0;
      end else begin
         if (req_valid && req_ready)
            expected_words.push_back(pack_rotation(req_quat_w, req_quat_x,
                                                   req_quat_y, req_quat_z));
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               $error("packed_rotation: unexpected transfer, actual %h", rsp_packed_rotation);
               error_count <= error_count + 1;
            end else begin
               want = expected_words.pop_front();
               if (want !== rsp_packed_rotation) begin
                  $error("packed_rotation: expected %h actual %h", want, rsp_packed_rotation);
                  error_count <= error_count + 1;
               end
            end
         end
      end
   end

endmodule

// ===== tb/sv/tb_quaternion_smallest_three_pack.sv =====
// top of the quaternion packer testbench: clock, reset, stimulus and verdict
// depends on qst_pkg, quaternion_smallest_three_pack and qst_checker
`timescale 1ns / 1ps

module tb_quaternion_smallest_three_pack;
   localparam int CB = 18;
   localparam int RANDOM_ITEMS = 1330;
   localparam int STALL_LIMIT = 5000;
   localparam logic signed [CB-1:0] MAX_POS = 18'sh1ffff;
   localparam logic signed [CB-1:0] MAX_NEG = 18'sh20000;
   localparam logic signed [CB-1:0] ONE = 18'sh04000;

   logic              clock = 0;
   logic              reset = 1;
   logic              req_valid = 0;
   logic              req_ready;
   logic signed [CB-1:0] req_quat_w = 0, req_quat_x = 0, req_quat_y = 0, req_quat_z = 0;
   logic              rsp_valid;
   logic              rsp_ready = 0;
   logic [31:0]       rsp_packed_rotation;
   int                error_count;
   int                pending_words;
   int                idle_cycles = 0;

   always #1 clock = ~clock;

   quaternion_smallest_three_pack #(.COMPONENT_BITS(CB)) dut (.*);

   qst_checker #(.COMPONENT_BITS(CB)) checker_i (.*);

   // receiver: alternates free-flowing stretches and stretches with random stalls
   always @(posedge clock) begin
      int phase;
      phase = ($urandom_range(0, 3) == 0) ? 1 : 0;
      if (reset) rsp_ready <= 0;
      else if ($time % 400 < 150) rsp_ready <= 1;
      else rsp_ready <= ($urandom_range(0, 2) != 0) || phase == 1;
   end

   // watchdog on cycles with no transfer on either channel
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles > STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   function automatic logic signed [CB-1:0] random_component();
      case ($urandom_range(0, 5))
         0: return MAX_NEG;
         1: return MAX_POS;
         2: return CB'($signed($urandom_range(0, 64)) - 32);
         3: return CB'($urandom_range(0, 2 * 16384) - 16384);
         default: return CB'($urandom);
      endcase
   endfunction

   // presents one item; valid stays high across back-to-back items
   task automatic send_quat(input logic signed [CB-1:0] w, x, y, z);
      req_valid <= 1;
      req_quat_w <= w; req_quat_x <= x; req_quat_y <= y; req_quat_z <= z;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic pause_sender(input int cycles);
      req_valid <= 0;
      repeat (cycles) @(posedge clock);
   endtask

   initial begin
      int burst;
      logic signed [CB-1:0] t;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_quat(0, 0, 0, 0);
      send_quat(ONE, 0, 0, 0);
      send_quat(-ONE, 0, 0, 0);
      send_quat(0, ONE, 0, 0);
      send_quat(0, 0, -ONE, 0);
      send_quat(0, 0, 0, ONE);
      send_quat(ONE, ONE, ONE, ONE);
      send_quat(-ONE, -ONE, ONE, ONE);
      send_quat(MAX_NEG, MAX_NEG, MAX_NEG, MAX_NEG);
      send_quat(MAX_POS, MAX_NEG, 0, 0);
      send_quat(MAX_NEG, MAX_POS, 1, -1);
      send_quat(MAX_POS, MAX_POS, MAX_POS, MAX_POS);
      send_quat(1, 0, 0, 0);
      send_quat(0, 0, 0, -1);
      send_quat(-1, 1, -1, 1);
      send_quat(ONE, ONE, -ONE, 0);
      send_quat(11585, 11585, 0, 0);
      send_quat(0, -11585, 11585, 0);
      send_quat(0, 0, MAX_NEG, MAX_POS);
      send_quat(MAX_POS, 0, 0, MAX_NEG);
      pause_sender(2);
      // hold off until the pipeline drains
      while (pending_words != 0) @(posedge clock);
      for (int i = 0; i < RANDOM_ITEMS; ) begin
         burst = $urandom_range(1, 40);
         for (int j = 0; j < burst && i < RANDOM_ITEMS; j++, i++) begin
            if ($urandom_range(0, 4) == 0) begin
               // exact magnitude tie between w and x, with y and z scaled down by four
               t = random_component();
               send_quat(t, ($urandom_range(0, 1) ? t : -t), random_component() >>> 2,
                         random_component() >>> 2);
            end else
               send_quat(random_component(), random_component(), random_component(),
                         random_component());
         end
         if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 12));
      end
      req_valid <= 0;
      while (pending_words != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (error_count == 0 && pending_words == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/qst_pkg.sv
rtl/core/qst_front.sv
rtl/core/qst_queue.sv
rtl/core/qst_back.sv
rtl/core/quaternion_smallest_three_pack.sv
tb/sv/qst_checker.sv
tb/sv/tb_quaternion_smallest_three_pack.sv
